FILE: hw/rtl/llpa_pkg.sv
// llpa_pkg: shared types and constants for the least-loaded partition assigner
// depends on nothing; used by the channel interfaces, llpa_argmin and the top level
package llpa_pkg;

	localparam int NUM_PARTITIONS = 8;
	localparam int MAX_PACKETS    = 65536;

	localparam int PART_W  = $clog2(NUM_PARTITIONS);
	localparam int LOAD_W  = 64;
	localparam int ID_W    = 16;
	localparam int CNT_W   = 17;
	localparam int CNT_MAX = (1 << CNT_W) - 1;

	localparam logic [CNT_W-1:0] COUNT_LIMIT =
		CNT_W'((MAX_PACKETS > CNT_MAX) ? CNT_MAX : MAX_PACKETS);

	localparam logic [PART_W-1:0] LAST_PART = PART_W'(NUM_PARTITIONS - 1);

	localparam logic KIND_ASSIGN  = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic [ID_W-1:0]   packet_id;
		logic [LOAD_W-1:0] work_amount;
		logic              batch_end;
	} in_word_t;

	typedef struct packed {
		logic              kind;
		logic [ID_W-1:0]   packet_id_out;
		logic [PART_W-1:0] partition;
		logic [LOAD_W-1:0] load_total;
		logic [CNT_W-1:0]  packet_count;
		logic              last;
	} out_word_t;

endpackage

FILE: hw/rtl/llpa_in_if.sv
// llpa_in_if: valid/ready channel carrying one packet word
// depends on llpa_pkg
interface llpa_in_if;
	logic              valid;
	logic              ready;
	llpa_pkg::in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/llpa_out_if.sv
// llpa_out_if: valid/ready channel carrying one result word
// depends on llpa_pkg
interface llpa_out_if;
	logic               valid;
	logic               ready;
	llpa_pkg::out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/llpa_argmin.sv
// llpa_argmin: pairwise compare tree that finds the least loaded partition
// ties resolve to the lower partition number; depends on llpa_pkg
module llpa_argmin (
	input  logic [llpa_pkg::LOAD_W-1:0] loads [llpa_pkg::NUM_PARTITIONS],
	output logic [llpa_pkg::PART_W-1:0] best
);

	localparam int SIZE = 1 << llpa_pkg::PART_W;

	logic [llpa_pkg::LOAD_W-1:0] lv_load [llpa_pkg::PART_W+1][SIZE];
	logic [llpa_pkg::PART_W-1:0] lv_idx  [llpa_pkg::PART_W+1][SIZE];

	always_comb begin
		for (int l = 0; l <= llpa_pkg::PART_W; l++) begin
			for (int i = 0; i < SIZE; i++) begin
				lv_load[l][i] = '1;
				lv_idx[l][i]  = '0;
			end
		end
		// leaves; padding slots sit at full load and lose every tie
		for (int i = 0; i < SIZE; i++) begin
			if (i < llpa_pkg::NUM_PARTITIONS) begin
				lv_load[0][i] = loads[i];
			end
			lv_idx[0][i] = llpa_pkg::PART_W'(i);
		end
		for (int l = 0; l < llpa_pkg::PART_W; l++) begin
			for (int i = 0; i < (SIZE >> (l + 1)); i++) begin
				if (lv_load[l][2*i+1] < lv_load[l][2*i]) begin
					lv_load[l+1][i] = lv_load[l][2*i+1];
					lv_idx[l+1][i]  = lv_idx[l][2*i+1];
				end else begin
					lv_load[l+1][i] = lv_load[l][2*i];
					lv_idx[l+1][i]  = lv_idx[l][2*i];
				end
			end
		end
		best = lv_idx[llpa_pkg::PART_W][0];
	end

endmodule

FILE: hw/rtl/least_loaded_partition_assign.sv
// least_loaded_partition_assign: greedy least-loaded assignment of packets to partitions
// depends on llpa_pkg, llpa_in_if, llpa_out_if and llpa_argmin
//
//   channel  dir  word        handshake
//   pkt      in   in_word_t   valid/ready, taken when both high
//   res      out  out_word_t  valid/ready, taken when both high
//
// a packet is held in the input register, then argmin and the saturating add
// write its assignment word into the result register
// one packet per cycle when res is ready and no summary runs, bound by the load RMW
// a batch end adds one summary word per partition, input held meanwhile
// reset clears loads, counts and all valid flags; a stalled result holds the pipe
module least_loaded_partition_assign (
	input logic      clk,
	input logic      arst_n,
	llpa_in_if.sink  pkt,
	llpa_out_if.source res
);

	logic                         valid_s1;
	llpa_pkg::in_word_t           word_s1;

	logic [llpa_pkg::LOAD_W-1:0]  load_q  [llpa_pkg::NUM_PARTITIONS];
	logic [llpa_pkg::CNT_W-1:0]   count_q [llpa_pkg::NUM_PARTITIONS];

	logic                         sum_active_q;
	logic [llpa_pkg::PART_W-1:0]  sum_idx_q;

	logic                         out_valid_q;
	llpa_pkg::out_word_t          out_q;

	logic                         out_free;
	logic                         s1_fire;
	logic                         sum_fire;
	logic [llpa_pkg::PART_W-1:0]  best;
	logic [llpa_pkg::LOAD_W:0]    sum_wide;
	logic [llpa_pkg::LOAD_W-1:0]  new_load;
	logic [llpa_pkg::CNT_W-1:0]   new_count;

	llpa_argmin u_argmin (
		.loads (load_q),
		.best  (best)
	);

	assign out_free  = !out_valid_q || res.ready;
	assign s1_fire   = valid_s1 && out_free && !sum_active_q;
	assign sum_fire  = sum_active_q && out_free;
	assign pkt.ready = !valid_s1 || s1_fire;

	assign sum_wide = {1'b0, load_q[best]} + {1'b0, word_s1.work_amount};

	always_comb begin
		new_load  = sum_wide[llpa_pkg::LOAD_W] ? '1 : sum_wide[llpa_pkg::LOAD_W-1:0];
		new_count = count_q[best];
		if (count_q[best] < llpa_pkg::COUNT_LIMIT) begin
			new_count = count_q[best] + llpa_pkg::CNT_W'(1);
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			valid_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.ready && pkt.valid) begin
			word_s1 <= pkt.data;
		end
	end

	// partition state and summary sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < llpa_pkg::NUM_PARTITIONS; p++) begin
				load_q[p]  <= '0;
				count_q[p] <= '0;
			end
			sum_active_q <= 1'b0;
			sum_idx_q    <= '0;
		end else if (s1_fire) begin
			load_q[best]  <= new_load;
			count_q[best] <= new_count;
			if (word_s1.batch_end) begin
				sum_active_q <= 1'b1;
				sum_idx_q    <= '0;
			end
		end else if (sum_fire) begin
			if (sum_idx_q == llpa_pkg::LAST_PART) begin
				for (int p = 0; p < llpa_pkg::NUM_PARTITIONS; p++) begin
					load_q[p]  <= '0;
					count_q[p] <= '0;
				end
				sum_active_q <= 1'b0;
				sum_idx_q    <= '0;
			end else begin
				sum_idx_q <= sum_idx_q + llpa_pkg::PART_W'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_fire || sum_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_q.kind          <= llpa_pkg::KIND_ASSIGN;
			out_q.packet_id_out <= word_s1.packet_id;
			out_q.partition     <= best;
			out_q.load_total    <= '0;
			out_q.packet_count  <= '0;
			out_q.last          <= !word_s1.batch_end;
		end else if (sum_fire) begin
			out_q.kind          <= llpa_pkg::KIND_SUMMARY;
			out_q.packet_id_out <= '0;
			out_q.partition     <= sum_idx_q;
			out_q.load_total    <= load_q[sum_idx_q];
			out_q.packet_count  <= count_q[sum_idx_q];
			out_q.last          <= (sum_idx_q == llpa_pkg::LAST_PART);
		end
	end

	assign res.valid = out_valid_q;
	assign res.data  = out_q;

`ifndef SYNTH
	a_no_packet_during_summary: assert property (@(posedge clk) disable iff (!arst_n)
		sum_active_q |-> !s1_fire)
		else $error("packet word processed during summary burst");

	a_clear_after_summary: assert property (@(posedge clk) disable iff (!arst_n)
		sum_fire && sum_idx_q == llpa_pkg::LAST_PART |=>
			load_q[0] == '0 && count_q[0] == '0 &&
			load_q[llpa_pkg::LAST_PART] == '0 && count_q[llpa_pkg::LAST_PART] == '0)
		else $error("partition state not cleared after batch summary");

	a_assign_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.kind == llpa_pkg::KIND_ASSIGN |->
			out_q.load_total == '0 && out_q.packet_count == '0)
		else $error("assignment word carries load or count");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |-> new_count <= llpa_pkg::COUNT_LIMIT)
		else $error("partition count beyond limit");
`endif

endmodule
